// ----- rtl/alsd_pkg.sv -----
// Shared types and constants for the addressable LED strip driver.
package alsd_pkg;

   localparam int MAX_LEDS_DEF     = 256;
   localparam int BITS_PER_LED_DEF = 24;

   localparam int OP_W        = 2;
   localparam int INDEX_W     = 8;
   localparam int COLOR_W     = 24;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 9;
   localparam int TICK_W      = 8;
   localparam int BITPOS_W    = 5;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 9;

   localparam logic [COUNT_W-1:0] LED_COUNT_RST   = 9'd0;
   localparam logic [TICK_W-1:0]  ZERO_HIGH_RST   = 8'd4;
   localparam logic [TICK_W-1:0]  ONE_HIGH_RST    = 8'd10;
   localparam logic [TICK_W-1:0]  BIT_PERIOD_RST  = 8'd15;
   localparam logic [TICK_W-1:0]  MIN_PERIOD      = 8'd2;

   typedef enum logic [OP_W-1:0] {
      OP_TICK       = 2'd0,
      OP_SET_COLOR  = 2'd1,
      OP_CLEAR_SEND = 2'd2,
      OP_SEND       = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_INIT  = 2'd1,
      ST_OUT_RANGE = 2'd2,
      ST_BUSY      = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LED_COUNT  = 2'd0,
      CSR_ZERO_HIGH  = 2'd1,
      CSR_ONE_HIGH   = 2'd2,
      CSR_BIT_PERIOD = 2'd3
   } csr_reg_type;

endpackage

// ----- rtl/addressable_led_strip_driver_top.sv -----
// Top level of the addressable LED strip driver: color store, frame sequencer, bit timer.
//
//   channel  direction  payload                                          beat when
//   req_     in         tuser: operation; tdata: led_index, color_grb   tvalid & tready
//   rsp_     out        tdata: data_level, is_busy, status               tvalid & tready
//   csr_     in         csr_index selects register, csr_wdata value      csr_we high
//
// Each request beat yields one response beat, registered in the cycle of acceptance.
// After a beat that starts a frame or moves the frame to the next LED, req_tready stays
// low until the color store result lands in the shift register.
// A stalled response holds the output register; req_tready follows it, so no beat is lost.
// Synchronous reset clears the sequencer, the registers and the response valid; the color
// store is not cleared and an entry reads as garbage until written.
module addressable_led_strip_driver_top #(
   parameter int MAX_LEDS     = alsd_pkg::MAX_LEDS_DEF,
   parameter int BITS_PER_LED = alsd_pkg::BITS_PER_LED_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] led_index, [31:8] color_grb
   input  logic [alsd_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] operation
   input  logic [alsd_pkg::OP_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] data_level, [1] is_busy, [3:2] status, [7:4] zero
   output logic [alsd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [alsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [alsd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import alsd_pkg::*;

   localparam int ADDR_W  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int SHIFT_W = BITS_PER_LED;
   localparam int PAD_W   = BITS_PER_LED - COLOR_W;

   // configuration registers
   logic [COUNT_W-1:0] led_count_ff;
   logic [TICK_W-1:0]  zero_high_ff;
   logic [TICK_W-1:0]  one_high_ff;
   logic [TICK_W-1:0]  period_cfg_ff;

   // frame sequencer state
   logic [COUNT_W-1:0]  led_pos_ff,  led_pos_in;
   logic [BITPOS_W-1:0] bit_pos_ff,  bit_pos_in;
   logic [TICK_W-1:0]   tick_ff,     tick_in;
   logic [SHIFT_W-1:0]  shift_ff,    shift_in;
   logic                sending_ff,  sending_in;
   logic                clearing_ff, clearing_in;
   logic                level_ff,    level_in;
   logic                load_pend_ff, load_pend_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff,  rsp_data_in;

   // request fields
   op_type              op;
   logic [INDEX_W-1:0]  led_index;
   logic [COLOR_W-1:0]  color_grb;
   logic                accept;

   // derived timing
   logic [COUNT_W-1:0]  count_eff;
   logic [TICK_W-1:0]   period;
   logic [TICK_W-1:0]   period_m1;
   logic [TICK_W-1:0]   high_raw;
   logic [TICK_W-1:0]   high_time;
   logic [TICK_W:0]     tick_inc;
   logic [BITPOS_W:0]   bit_inc;
   logic [COUNT_W-1:0]  led_inc;
   logic                load_start;
   status_type          status;

   // color store ports
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [COLOR_W-1:0]  wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [COLOR_W-1:0]  rd_data;

   assign op        = op_type'(req_tuser);
   assign led_index = req_tdata[INDEX_W-1:0];
   assign color_grb = req_tdata[INDEX_W+COLOR_W-1:INDEX_W];

   // hold requests while a store read is in flight or the response is stalled
   assign req_tready = !load_pend_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // counts beyond the store depth act as the depth
   assign count_eff = (32'(led_count_ff) > MAX_LEDS) ? COUNT_W'(MAX_LEDS) : led_count_ff;

   // bit timing: period of at least two ticks, high time clamped below the period
   assign period    = (period_cfg_ff < MIN_PERIOD) ? MIN_PERIOD : period_cfg_ff;
   assign period_m1 = period - 8'd1;
   assign high_raw  = shift_ff[SHIFT_W-1] ? one_high_ff : zero_high_ff;
   assign high_time = (high_raw > period_m1) ? period_m1 : high_raw;
   assign tick_inc  = {1'b0, tick_ff} + 9'd1;
   assign bit_inc   = {1'b0, bit_pos_ff} + 6'd1;
   assign led_inc   = led_pos_ff + 9'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff  <= LED_COUNT_RST;
         zero_high_ff  <= ZERO_HIGH_RST;
         one_high_ff   <= ONE_HIGH_RST;
         period_cfg_ff <= BIT_PERIOD_RST;
      end else if (csr_we) begin
         case (csr_reg_type'(csr_index))
            CSR_LED_COUNT:  led_count_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_ZERO_HIGH:  zero_high_ff  <= csr_wdata[TICK_W-1:0];
            CSR_ONE_HIGH:   one_high_ff   <= csr_wdata[TICK_W-1:0];
            CSR_BIT_PERIOD: period_cfg_ff <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      led_pos_in  = led_pos_ff;
      bit_pos_in  = bit_pos_ff;
      tick_in     = tick_ff;
      shift_in    = shift_ff;
      sending_in  = sending_ff;
      clearing_in = clearing_ff;
      level_in    = level_ff;
      load_start  = 1'b0;
      status      = ST_OK;

      // the store read of the previous beat lands here; a clearing frame sends zeros
      if (load_pend_ff) begin
         shift_in = clearing_ff ? '0 : (SHIFT_W'(rd_data) << PAD_W);
      end

      if (accept) begin
         case (op)
            OP_TICK: begin
               if (!sending_ff) begin
                  level_in = 1'b0;
               end else begin
                  level_in = (tick_ff < high_time);
                  if (tick_inc >= {1'b0, period}) begin
                     tick_in = '0;
                     if (bit_inc >= (BITPOS_W+1)'(BITS_PER_LED)) begin
                        bit_pos_in = '0;
                        if (led_inc >= count_eff) begin
                           // last LED done: end the frame
                           sending_in  = 1'b0;
                           clearing_in = 1'b0;
                           led_pos_in  = '0;
                           shift_in    = '0;
                        end else begin
                           led_pos_in = led_inc;
                           load_start = 1'b1;
                        end
                     end else begin
                        bit_pos_in = bit_inc[BITPOS_W-1:0];
                        shift_in   = shift_ff << 1;
                     end
                  end else begin
                     tick_in = tick_inc[TICK_W-1:0];
                  end
               end
            end
            default: begin
               if (count_eff == '0) begin
                  status = ST_NOT_INIT;
               end else if (sending_ff) begin
                  status = ST_BUSY;
               end else if (op == OP_SET_COLOR) begin
                  if ({1'b0, led_index} >= count_eff) begin
                     status = ST_OUT_RANGE;
                  end
               end else begin
                  clearing_in = (op == OP_CLEAR_SEND);
                  sending_in  = 1'b1;
                  led_pos_in  = '0;
                  bit_pos_in  = '0;
                  tick_in     = '0;
                  load_start  = 1'b1;
               end
            end
         endcase
      end

      load_pend_in = load_start;
   end

   // color store access: color writes, zeroing on a clearing frame, entry fetch
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ADDR_W'({{ADDR_W{1'b0}}, led_index});
      wr_data = color_grb;
      rd_en   = 1'b0;
      rd_addr = ADDR_W'({{ADDR_W{1'b0}}, led_pos_in});
      if (accept && op == OP_SET_COLOR && status == ST_OK) begin
         wr_en = 1'b1;
      end else if (load_start && clearing_in) begin
         wr_en   = 1'b1;
         wr_addr = ADDR_W'({{ADDR_W{1'b0}}, led_pos_in});
         wr_data = '0;
      end else if (load_start) begin
         rd_en = 1'b1;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({status, sending_in, level_in});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_pos_ff   <= '0;
         bit_pos_ff   <= '0;
         tick_ff      <= '0;
         shift_ff     <= '0;
         sending_ff   <= 1'b0;
         clearing_ff  <= 1'b0;
         level_ff     <= 1'b0;
         load_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         led_pos_ff   <= led_pos_in;
         bit_pos_ff   <= bit_pos_in;
         tick_ff      <= tick_in;
         shift_ff     <= shift_in;
         sending_ff   <= sending_in;
         clearing_ff  <= clearing_in;
         level_ff     <= level_in;
         load_pend_ff <= load_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   alsd_color_ram #(
      .DEPTH  (MAX_LEDS),
      .ADDR_W (ADDR_W)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ----- rtl/alsd_color_ram.sv -----
// Color store: one write port, one registered read port.
module alsd_color_ram #(
   parameter int DEPTH  = alsd_pkg::MAX_LEDS_DEF,
   parameter int ADDR_W = 8
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [alsd_pkg::COLOR_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [alsd_pkg::COLOR_W-1:0] rd_data
);
   import alsd_pkg::*;

   logic [COLOR_W-1:0] color_mem [DEPTH];
   logic [COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         color_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= color_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- bench/tb_addressable_led_strip_driver_top.sv -----
// Self-checking bench for the LED strip driver: predicts every response beat and checks it.
`timescale 1ns / 1ps

module tb_addressable_led_strip_driver_top;
   import alsd_pkg::*;

   // One response beat as the predictor sees it.
   typedef struct packed {
      logic       level;
      logic       busy;
      status_type status;
   } line_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Idle rates in percent; changed between traffic modes.
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int fail_count   = 0;
   int beats_sent   = 0;

   // Expected response beats, oldest first.
   line_result_type line_expect_q[$];

   // Shadow of the block: color store, frame sequencer, bit timer and registers.
   logic [COLOR_W-1:0]  mem_color [MAX_LEDS_DEF];
   bit                  mem_known [MAX_LEDS_DEF];
   logic                frame_active = 1'b0;
   logic                clear_pass   = 1'b0;
   logic [COUNT_W-1:0]  pos_led      = '0;
   logic [BITPOS_W-1:0] pos_bit      = '0;
   logic [TICK_W-1:0]   tick_count   = '0;
   logic [COLOR_W-1:0]  shift_reg    = '0;
   logic                line_out     = 1'b0;
   logic [COUNT_W-1:0]  reg_count     = LED_COUNT_RST;
   logic [TICK_W-1:0]   reg_zero_high = ZERO_HIGH_RST;
   logic [TICK_W-1:0]   reg_one_high  = ONE_HIGH_RST;
   logic [TICK_W-1:0]   reg_period    = BIT_PERIOD_RST;

   addressable_led_strip_driver_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] led_index, [31:8] color_grb
      .req_tuser  (req_tuser),   // [1:0] operation
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [0] data_level, [1] is_busy, [3:2] status
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the response side at the current rate; one decision per cycle.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Counts above the store size behave as the store size.
   function automatic logic [COUNT_W-1:0] effective_count();
      return (reg_count > COUNT_W'(MAX_LEDS_DEF)) ? COUNT_W'(MAX_LEDS_DEF) : reg_count;
   endfunction

   // Load the next LED into the shift register; a clearing frame zeroes it instead.
   function automatic void fetch_entry(logic [COUNT_W-1:0] pos);
      if (clear_pass) begin
         mem_color[pos] = '0;
         mem_known[pos] = 1'b1;
         shift_reg      = '0;
      end else begin
         shift_reg = mem_color[pos];
      end
   endfunction

   // One timebase step of the serial line.
   function automatic void advance_waveform();
      logic [TICK_W-1:0] period;
      logic [TICK_W-1:0] high;
      logic              data_bit;
      if (!frame_active) begin
         line_out = 1'b0;
         return;
      end
      period   = (reg_period < MIN_PERIOD) ? MIN_PERIOD : reg_period;
      data_bit = shift_reg[(BITS_PER_LED_DEF - 1) - pos_bit];
      high     = data_bit ? reg_one_high : reg_zero_high;
      if (high > period - 8'd1)
         high = period - 8'd1;
      line_out   = (tick_count < high);
      tick_count = tick_count + 8'd1;
      if (tick_count >= period) begin
         tick_count = '0;
         pos_bit    = pos_bit + 5'd1;
         if (pos_bit >= BITPOS_W'(BITS_PER_LED_DEF)) begin
            pos_bit = '0;
            pos_led = pos_led + 9'd1;
            if (pos_led >= effective_count()) begin
               frame_active = 1'b0;
               clear_pass   = 1'b0;
               pos_led      = '0;
               shift_reg    = '0;
            end else begin
               fetch_entry(pos_led);
            end
         end
      end
   endfunction

   // Work out the response to one accepted request beat and queue it.
   function automatic void predict_line_response(op_type op, logic [INDEX_W-1:0] idx,
                                                 logic [COLOR_W-1:0] color);
      status_type         st = ST_OK;
      logic [COUNT_W-1:0] count;
      count = effective_count();
      if (op == OP_TICK) begin
         advance_waveform();
      end else if (count == '0) begin
         st = ST_NOT_INIT;
      end else if (frame_active) begin
         st = ST_BUSY;
      end else if (op == OP_SET_COLOR) begin
         if ({1'b0, idx} >= count) begin
            st = ST_OUT_RANGE;
         end else begin
            mem_color[idx] = color;
            mem_known[idx] = 1'b1;
         end
      end else begin
         clear_pass   = (op == OP_CLEAR_SEND);
         frame_active = 1'b1;
         pos_led      = '0;
         pos_bit      = '0;
         tick_count   = '0;
         fetch_entry('0);
      end
      line_expect_q.push_back('{line_out, frame_active, st});
   endfunction

   // A plain send may only start when every LED it will read has been written.
   function automatic bit colors_all_known();
      for (int i = 0; i < int'(effective_count()); i++)
         if (!mem_known[i])
            return 1'b0;
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Response checker
   // ------------------------------------------------------------------

   always @(posedge clock) begin : check_line_response
      line_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (line_expect_q.size() == 0) begin
            $error("response beat with no request outstanding: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            want = line_expect_q.pop_front();
            if (rsp_tdata[0] !== want.level) begin
               $error("data_level: expected %0d, got %0d", want.level, rsp_tdata[0]);
               fail_count++;
            end
            if (rsp_tdata[1] !== want.busy) begin
               $error("is_busy: expected %0d, got %0d", want.busy, rsp_tdata[1]);
               fail_count++;
            end
            if (rsp_tdata[3:2] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tdata[3:2]);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Drive one request beat, hold it until taken, then predict its response.
   task automatic send_beat(op_type op, logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] color);
      // Never let a plain send read LEDs that were never written; clear them instead.
      if (op == OP_SEND && !frame_active && effective_count() != '0 && !colors_all_known())
         op = OP_CLEAR_SEND;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {color, idx};
      do
         @(posedge clock);
      while (!req_tready);
      predict_line_response(op, idx, color);
      beats_sent++;
   endtask

   // Random non-tick request with random fields.
   task automatic send_stray_beat();
      send_beat(op_type'($urandom_range(1, 3)), INDEX_W'($urandom), COLOR_W'($urandom));
   endtask

   // Tick until the frame in flight is done, mixing in refused requests now and then.
   task automatic finish_frame(int stray_pct);
      while (frame_active) begin
         if ($urandom_range(99) < stray_pct)
            send_stray_beat();
         else
            send_beat(OP_TICK, INDEX_W'($urandom), COLOR_W'($urandom));
      end
   endtask

   // Drop valid and wait for every outstanding response, then let the clock run on quietly.
   task automatic settle_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (line_expect_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write; the block must be quiet when this is called.
   task automatic write_csr(csr_reg_type which, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (which)
         CSR_LED_COUNT:  reg_count     = value;
         CSR_ZERO_HIGH:  reg_zero_high = value[TICK_W-1:0];
         CSR_ONE_HIGH:   reg_one_high  = value[TICK_W-1:0];
         CSR_BIT_PERIOD: reg_period    = value[TICK_W-1:0];
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // After reset the LED count is zero: every request but a tick is refused as uninitialized.
   task automatic test_not_initialized();
      send_beat(OP_TICK, 8'h00, 24'h000000);
      send_beat(OP_SET_COLOR, 8'h00, 24'hFFFFFF);
      send_beat(OP_CLEAR_SEND, 8'hFF, 24'h000000);
      send_beat(OP_SEND, 8'hFF, 24'hFFFFFF);
      send_beat(OP_TICK, 8'hFF, 24'hFFFFFF);
      settle_block();
   endtask

   // Two LEDs, all-ones and all-zeros, with high times at both extremes.
   // Covers index bounds, refusal while busy, and busy taking priority over bounds.
   task automatic test_frame_timing();
      write_csr(CSR_LED_COUNT, 9'd2);
      write_csr(CSR_ZERO_HIGH, 9'd0);      // zero bits stay low the whole bit
      write_csr(CSR_ONE_HIGH, 9'd255);     // clamps to period minus one
      write_csr(CSR_BIT_PERIOD, 9'd3);
      send_beat(OP_SET_COLOR, 8'd0, 24'hFFFFFF);
      send_beat(OP_SET_COLOR, 8'd1, 24'h000000);
      send_beat(OP_SET_COLOR, 8'd2, 24'h123456);   // first index past the count
      send_beat(OP_SET_COLOR, 8'd255, 24'hFFFFFF);
      send_beat(OP_TICK, 8'd0, 24'h0);             // idle tick keeps the line low
      send_beat(OP_SEND, 8'd0, 24'h0);             // start does not move the line
      send_beat(OP_TICK, 8'd0, 24'h0);
      send_beat(OP_SET_COLOR, 8'd255, 24'hABCDEF); // busy wins over out of range
      send_beat(OP_SEND, 8'd0, 24'h0);
      send_beat(OP_CLEAR_SEND, 8'd0, 24'h0);
      finish_frame(0);
      send_beat(OP_TICK, 8'd0, 24'h0);
      settle_block();
   endtask

   // Clear-and-send zeroes the LEDs it passes; a following plain send shows zeros.
   task automatic test_clear_and_resend();
      write_csr(CSR_ZERO_HIGH, 9'd0);
      write_csr(CSR_ONE_HIGH, 9'd1);
      write_csr(CSR_BIT_PERIOD, 9'd2);
      send_beat(OP_SET_COLOR, 8'd0, 24'hFFFFFF);
      send_beat(OP_SET_COLOR, 8'd1, 24'h800001);
      send_beat(OP_CLEAR_SEND, 8'd0, 24'h0);
      finish_frame(0);
      send_beat(OP_SEND, 8'd0, 24'h0);
      finish_frame(0);
      settle_block();
   endtask

   // Count above the store size acts as the full store in the bound check;
   // period below two acts as two.
   task automatic test_large_count();
      write_csr(CSR_LED_COUNT, 9'd511);
      send_beat(OP_SET_COLOR, 8'd255, 24'hA5A5A5);
      send_beat(OP_SET_COLOR, 8'd0, 24'h5A5A5A);
      settle_block();
      write_csr(CSR_LED_COUNT, 9'd1);
      write_csr(CSR_BIT_PERIOD, 9'd1);
      write_csr(CSR_ZERO_HIGH, 9'd1);
      write_csr(CSR_ONE_HIGH, 9'd1);
      send_beat(OP_SEND, 8'd0, 24'h0);
      finish_frame(2);
      settle_block();
   endtask

   // Longest bit period on one LED: run through the first bit and into the second.
   // The frame is left running; nothing follows this test.
   task automatic test_long_period();
      write_csr(CSR_LED_COUNT, 9'd1);
      write_csr(CSR_BIT_PERIOD, 9'd255);
      write_csr(CSR_ZERO_HIGH, 9'd254);
      write_csr(CSR_ONE_HIGH, 9'd255);
      send_beat(OP_SET_COLOR, 8'd0, 24'h5AC33C);
      send_beat(OP_SEND, 8'd0, 24'h0);
      repeat (260)
         send_beat(OP_TICK, INDEX_W'($urandom), COLOR_W'($urandom));
      send_stray_beat();
      settle_block();
   endtask

   // One phase: fresh register settings, then one or two frames or uninitialized noise.
   task automatic run_random_phase();
      logic [TICK_W-1:0] period;
      logic [COUNT_W-1:0] count;
      int frames;
      count  = ($urandom_range(9) == 0) ? 9'd0 : COUNT_W'($urandom_range(1, 3));
      period = TICK_W'($urandom_range(0, 6));
      write_csr(CSR_LED_COUNT, count);
      write_csr(CSR_BIT_PERIOD, {1'b0, period});
      write_csr(CSR_ZERO_HIGH, $urandom_range(1) ? 9'($urandom_range(0, period + 1))
                                                 : 9'($urandom_range(0, 255)));
      write_csr(CSR_ONE_HIGH, $urandom_range(1) ? 9'($urandom_range(0, period + 1))
                                                : 9'($urandom_range(0, 255)));
      if (count == '0) begin
         repeat ($urandom_range(4, 10)) begin
            if ($urandom_range(3) == 0)
               send_beat(OP_TICK, INDEX_W'($urandom), COLOR_W'($urandom));
            else
               send_stray_beat();
         end
      end else begin
         frames = $urandom_range(1, 2);
         repeat (frames) begin
            // Load the strip, plus stray writes and idle ticks.
            for (int i = 0; i < int'(count); i++)
               if (!mem_known[i] || $urandom_range(1))
                  send_beat(OP_SET_COLOR, INDEX_W'(i), COLOR_W'($urandom));
            repeat ($urandom_range(0, 3)) begin
               if ($urandom_range(1))
                  send_beat(OP_SET_COLOR, INDEX_W'($urandom), COLOR_W'($urandom));
               else
                  send_beat(OP_TICK, INDEX_W'($urandom), COLOR_W'($urandom));
            end
            if ($urandom_range(9) < 7)
               send_beat(OP_SEND, INDEX_W'($urandom), COLOR_W'($urandom));
            else
               send_beat(OP_CLEAR_SEND, INDEX_W'($urandom), COLOR_W'($urandom));
            finish_frame(10);
         end
      end
      settle_block();
   endtask

   // Random traffic under three idle patterns: sender light, receiver light, no idling.
   task automatic test_random_traffic();
      int goal;
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               req_idle_pct = 12;
               rsp_idle_pct = 51;
            end
            1: begin
               req_idle_pct = 51;
               rsp_idle_pct = 12;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         goal = beats_sent + 100;
         while (beats_sent < goal)
            run_random_phase();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      for (int i = 0; i < MAX_LEDS_DEF; i++) begin
         mem_color[i] = '0;
         mem_known[i] = 1'b0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed tests run under the first idle pattern; test_long_period runs last, with no idling.
      req_idle_pct = 12;
      rsp_idle_pct = 51;
      test_not_initialized();
      test_frame_timing();
      test_clear_and_resend();
      test_large_count();
      test_random_traffic();
      test_long_period();

      // Everything has been answered; keep the clock running so that any stray beat still shows.
      repeat (20) @(posedge clock);
      if (fail_count == 0 && line_expect_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/alsd_pkg.sv
rtl/alsd_color_ram.sv
rtl/addressable_led_strip_driver_top.sv
bench/tb_addressable_led_strip_driver_top.sv
